// File: rtl/rhpg_pkg.sv
// ----------------------------------------------------------------------------
// rhpg_pkg
// Shared constants, payload types and the sine table of the radial hand
// point generator.
// ----------------------------------------------------------------------------
package rhpg_pkg;

  localparam int RADIUS_BITS    = 8;
  localparam int TRIG_FRAC_BITS = 15;

  // Field widths of the stream payload
  localparam int AngleW  = 9;
  localparam int RadInW  = 8;
  localparam int OffW    = 9;
  localparam int IndexW  = 8;
  localparam int InDataW  = 24;
  localparam int OutDataW = 32;

  // Derived arithmetic widths
  localparam int TrigW   = TRIG_FRAC_BITS + 1;
  localparam int ProdW   = RADIUS_BITS + TrigW;
  localparam int MagW    = RADIUS_BITS + 1;
  localparam int TrigUp   = (TRIG_FRAC_BITS > 15) ? TRIG_FRAC_BITS - 15 : 0;
  localparam int TrigDown = (TRIG_FRAC_BITS < 15) ? 15 - TRIG_FRAC_BITS : 0;
  localparam int TrigHalf = (TrigDown > 0) ? (1 << (TrigDown - 1)) : 0;

  localparam logic [AngleW-1:0] FullTurn = AngleW'(360);
  localparam logic [AngleW-1:0] HalfTurn = AngleW'(180);
  localparam logic [AngleW-1:0] HalfMax  = AngleW'(179);
  localparam logic [7:0]        QuarterTurn = 8'd90;
  localparam logic [OffW-2:0]   OffMax   = '1;

  // round(sin(d) * 32768), d = 0..90
  localparam logic [15:0] SinQ15 [0:90] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
    16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
    16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
    16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
    16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
    16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
    16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
    16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
    16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
    16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
    16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
    16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
    16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
    16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
    16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
    16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
    16'd32768
  };

  typedef struct packed {
    logic [AngleW-1:0] angle;
    logic [RadInW-1:0] radius;
    logic              first_step;
    logic              last_step;
  } step_t;

  typedef struct packed {
    logic signed [OffW-1:0] x_offset;
    logic signed [OffW-1:0] y_offset;
    logic                   point_valid;
    logic [IndexW-1:0]      point_index;
    logic                   is_last;
  } point_t;

  // Table magnitude at TRIG_FRAC_BITS fraction bits; degrees above 90 clamp.
  function automatic logic [TrigW-1:0] trig_mag(input logic [7:0] deg);
    logic [6:0]  d;
    logic [31:0] t;
    d = (deg > QuarterTurn) ? 7'd90 : deg[6:0];
    t = {16'd0, SinQ15[d]};
    if (TrigDown > 0) begin
      t = (t + 32'(TrigHalf)) >> TrigDown;
    end else begin
      t = t << TrigUp;
    end
    return t[TrigW-1:0];
  endfunction

endpackage

// File: rtl/radial_hand_point_generator.sv
// ----------------------------------------------------------------------------
// radial_hand_point_generator
// Turns a hand angle and radius steps into signed pixel offsets, dropping
// points that repeat the last emitted one.
// ----------------------------------------------------------------------------
// An accepted request goes to the input register, its result to the output one.
// Throughput: 1 request per cycle unless the master side stalls; the table
// lookup, one multiply per axis and the compare with the stored point sit
// between the input and result register. Reset: asynchronous, active low;
// clears valid flags, the stored point and the emitted count.
module radial_hand_point_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // angle[8:0], radius[16:9], zero fill
  input  logic        s_axis_tuser,   // first_step
  input  logic        s_axis_tlast,   // last_step
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // x_offset[8:0], y_offset[17:9],
                                      // point_index[25:18], zero fill
  output logic        m_axis_tuser,   // point_valid
  output logic        m_axis_tlast    // is_last
);

  localparam int OffW = rhpg_pkg::OffW;
  localparam int MagW = rhpg_pkg::MagW;

  logic                  in_vld_q;
  rhpg_pkg::step_t       in_q;
  logic                  out_vld_q;
  rhpg_pkg::point_t      out_q, out_d;
  logic signed [OffW-1:0] prev_x_q, prev_y_q;
  logic [rhpg_pkg::IndexW-1:0] count_q;
  logic                  advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  // Angle fold and trig lookup
  logic [rhpg_pkg::AngleW-1:0]      a_red;
  logic                             neg;
  logic [7:0]                       g, cdeg;
  logic [rhpg_pkg::TrigW-1:0]       smag, cmag;
  logic [rhpg_pkg::RADIUS_BITS-1:0] r;
  logic [rhpg_pkg::ProdW-1:0]       xprod, yprod;
  logic [MagW-1:0]                  xm, ym;
  logic [OffW-2:0]                  xs, ys;
  logic                             yneg, axis, emit;
  logic signed [OffW-1:0]           x, y;
  logic [rhpg_pkg::IndexW-1:0]      idx;

  always_comb begin
    a_red = (in_q.angle >= rhpg_pkg::FullTurn) ? in_q.angle - rhpg_pkg::FullTurn
                                               : in_q.angle;
    neg   = a_red > rhpg_pkg::HalfMax;
    g     = neg ? 8'(a_red - rhpg_pkg::HalfTurn) : 8'(a_red);
    cdeg  = (g < rhpg_pkg::QuarterTurn) ? rhpg_pkg::QuarterTurn - g
                                        : g - rhpg_pkg::QuarterTurn;
    smag  = rhpg_pkg::trig_mag(g);
    cmag  = rhpg_pkg::trig_mag(cdeg);
    r     = rhpg_pkg::RADIUS_BITS'({{(rhpg_pkg::RADIUS_BITS){1'b0}}, in_q.radius});
    xprod = rhpg_pkg::ProdW'(r) * rhpg_pkg::ProdW'(smag);
    yprod = rhpg_pkg::ProdW'(r) * rhpg_pkg::ProdW'(cmag);
    xm    = MagW'(xprod >> rhpg_pkg::TRIG_FRAC_BITS);
    ym    = MagW'(yprod >> rhpg_pkg::TRIG_FRAC_BITS);
    // saturate magnitude, then apply sign (limits are symmetric)
    xs    = (xm > MagW'(rhpg_pkg::OffMax)) ? rhpg_pkg::OffMax : xm[OffW-2:0];
    ys    = (ym > MagW'(rhpg_pkg::OffMax)) ? rhpg_pkg::OffMax : ym[OffW-2:0];
    yneg  = (g < rhpg_pkg::QuarterTurn) ^ neg;
    x     = neg  ? -$signed({1'b0, xs}) : $signed({1'b0, xs});
    y     = yneg ? -$signed({1'b0, ys}) : $signed({1'b0, ys});
    // axis points are always emitted
    axis  = (g == rhpg_pkg::QuarterTurn) || (g == 8'd0);
    emit  = axis || in_q.first_step || (x != prev_x_q) || (y != prev_y_q);
    idx   = in_q.first_step ? '0 : count_q;

    out_d.x_offset    = x;
    out_d.y_offset    = y;
    out_d.point_valid = emit;
    out_d.point_index = emit ? idx : '0;
    out_d.is_last     = in_q.last_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      count_q   <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        if (emit) begin
          prev_x_q <= x;
          prev_y_q <= y;
          count_q  <= idx + 1'b1;
        end
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: load on handshake, hold otherwise
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.angle      <= s_axis_tdata[8:0];
      in_q.radius     <= s_axis_tdata[16:9];
      in_q.first_step <= s_axis_tuser;
      in_q.last_step  <= s_axis_tlast;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_q.point_index, out_q.y_offset, out_q.x_offset};
  assign m_axis_tuser  = out_q.point_valid;
  assign m_axis_tlast  = out_q.is_last;

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the radial hand point generator. A queue of radius
// steps is driven in random bursts. Each accepted request updates a local
// model of the hand geometry and the duplicate filter. Each result taken
// under random back-pressure is checked against the oldest predicted point.
// ----------------------------------------------------------------------------
module tb;

  localparam int LimitCycles = 200000;
  localparam int DrainCycles = 10;
  localparam int TrigDown = (rhpg_pkg::TRIG_FRAC_BITS < 15) ? 15 - rhpg_pkg::TRIG_FRAC_BITS : 0;
  localparam int TrigUpSh = (rhpg_pkg::TRIG_FRAC_BITS > 15) ? rhpg_pkg::TRIG_FRAC_BITS - 15 : 0;
  localparam int TrigRnd  = (1 << TrigDown) >> 1;

  typedef enum int {
    ReadyAlways,
    ReadyCoin,
    ReadySparse
  } ready_mode_e;

  typedef struct {
    rhpg_pkg::step_t step;
    bit              drain;
  } queued_step_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // round(sin(d) * 32768), d = 0..90
  int unsigned sine_lut [91] = '{
    0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
    5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

  queued_step_t     step_queue [$];
  rhpg_pkg::point_t pending_points [$];

  // model state of the duplicate filter
  int         last_x = 0;
  int         last_y = 0;
  logic [7:0] point_count = '0;

  rhpg_pkg::step_t cur_step;
  int          burst_left = 0;
  int          gap_left = 0;
  ready_mode_e ready_mode = ReadyAlways;
  int          mode_left = 0;
  int          fail_count = 0;

  radial_hand_point_generator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  function automatic int trig_scaled(int deg);
    int unsigned t;
    t = sine_lut[(deg > 90) ? 90 : deg];
    if (TrigDown > 0) begin
      return int'((t + TrigRnd) >> TrigDown);
    end
    return int'(t << TrigUpSh);
  endfunction

  function automatic int clamp_off(int v);
    if (v > 255) return 255;
    if (v < -255) return -255;
    return v;
  endfunction

  // Predict one step and advance the stored point and count.
  function automatic rhpg_pkg::point_t hand_point(rhpg_pkg::step_t s);
    int     ang, g, r, x, y, xm, ym;
    bit     neg, emit;
    rhpg_pkg::point_t p;
    ang = int'(s.angle);
    r   = int'(s.radius) & ((1 << rhpg_pkg::RADIUS_BITS) - 1);
    if (ang >= 360) ang -= 360;
    neg = ang > 179;
    g   = neg ? ang - 180 : ang;
    if (s.first_step) point_count = '0;
    if (g == 90) begin
      x = neg ? -r : r;
      y = 0;
      emit = 1'b1;
    end else if (g == 0) begin
      x = 0;
      y = neg ? r : -r;
      emit = 1'b1;
    end else begin
      xm = (r * trig_scaled(g)) >>> rhpg_pkg::TRIG_FRAC_BITS;
      ym = (r * trig_scaled((g < 90) ? 90 - g : g - 90)) >>> rhpg_pkg::TRIG_FRAC_BITS;
      x = xm;
      y = (g < 90) ? -ym : ym;
      if (neg) begin
        x = -x;
        y = -y;
      end
      emit = 1'b0;
    end
    x = clamp_off(x);
    y = clamp_off(y);
    if (!emit) emit = s.first_step || x != last_x || y != last_y;
    p.x_offset    = x[rhpg_pkg::OffW-1:0];
    p.y_offset    = y[rhpg_pkg::OffW-1:0];
    p.point_valid = emit;
    p.point_index = emit ? point_count : '0;
    p.is_last     = s.last_step;
    if (emit) begin
      last_x = x;
      last_y = y;
      point_count = point_count + 8'd1;
    end
    return p;
  endfunction

  task automatic queue_step(int angle, int radius, bit first, bit last, bit drain);
    queued_step_t q;
    q.step.angle      = angle[rhpg_pkg::AngleW-1:0];
    q.step.radius     = radius[rhpg_pkg::RadInW-1:0];
    q.step.first_step = first;
    q.step.last_step  = last;
    q.drain           = drain;
    step_queue.push_back(q);
  endtask

  // Request driver: bursts of requests with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_points.push_back(hand_point(cur_step));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (step_queue.size() == 0 ||
                     (step_queue[0].drain && pending_points.size() != 0)) begin
          // hold until every outstanding point is back
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_step = step_queue[0].step;
          void'(step_queue.pop_front());
          s_axis_tdata  <= {7'd0, cur_step.radius, cur_step.angle};
          s_axis_tuser  <= cur_step.first_step;
          s_axis_tlast  <= cur_step.last_step;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Result monitor and back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    rhpg_pkg::point_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.x_offset    = m_axis_tdata[8:0];
        got.y_offset    = m_axis_tdata[17:9];
        got.point_index = m_axis_tdata[25:18];
        got.point_valid = m_axis_tuser;
        got.is_last     = m_axis_tlast;
        if (pending_points.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected point: x=%0d y=%0d valid=%0b index=%0d last=%0b",
                     got.x_offset, got.y_offset, got.point_valid, got.point_index,
                     got.is_last);
          end
          fail_count++;
        end else begin
          want = pending_points.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("point mismatch: exp x=%0d y=%0d valid=%0b index=%0d last=%0b",
                       want.x_offset, want.y_offset, want.point_valid,
                       want.point_index, want.is_last);
              $display("                got x=%0d y=%0d valid=%0b index=%0d last=%0b",
                       got.x_offset, got.y_offset, got.point_valid,
                       got.point_index, got.is_last);
            end
            fail_count++;
          end
        end
      end
      if (mode_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 2));
        mode_left  = $urandom_range(10, 60);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        ReadyAlways: m_axis_tready <= 1'b1;
        ReadyCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
        default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    int  rand_items, len, ang, rad;
    bit  wrap_done, with_first, with_last, drain;
    rand_items = 0;
    wrap_done  = 1'b0;

    // step before any first step: compares against the reset point
    queue_step(45, 0, 0, 0, 0);
    // axis points at full radius, both folds
    queue_step(0, 255, 1, 0, 0);
    queue_step(90, 255, 0, 0, 0);
    queue_step(180, 255, 0, 0, 0);
    queue_step(270, 255, 0, 0, 0);
    queue_step(359, 255, 0, 1, 0);
    // angles past a full turn and either side of a half turn
    queue_step(360, 100, 1, 0, 0);
    queue_step(450, 100, 0, 0, 0);
    queue_step(511, 255, 0, 0, 0);
    queue_step(179, 255, 0, 0, 0);
    queue_step(181, 255, 0, 0, 0);
    // near-vertical hand: repeated points get dropped
    queue_step(1, 1, 1, 0, 0);
    queue_step(1, 2, 0, 0, 0);
    queue_step(1, 2, 0, 0, 0);
    queue_step(1, 3, 0, 0, 0);
    // axis repeats always emit
    queue_step(90, 3, 0, 0, 0);
    queue_step(90, 3, 0, 0, 0);
    queue_step(91, 200, 0, 1, 0);
    queue_step(89, 255, 1, 1, 0);
    queue_step(0, 0, 0, 0, 0);
    queue_step(270, 0, 0, 0, 0);
    queue_step(200, 0, 1, 1, 0);

    while (rand_items < 430) begin
      if (!wrap_done && rand_items >= 100) begin
        // long hand, mostly axis points, to wrap the point count
        wrap_done = 1'b1;
        for (int i = 0; i < 265; i++) begin
          ang = ($urandom_range(0, 4) != 0) ? 90 * $urandom_range(0, 5)
                                            : $urandom_range(0, 511);
          queue_step(ang, $urandom_range(0, 255), i == 0, i == 264, i == 0);
        end
        rand_items += 265;
      end else if ($urandom_range(0, 6) == 0) begin
        queue_step($urandom_range(0, 511), $urandom_range(0, 255),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0);
        rand_items++;
      end else begin
        len = $urandom_range(1, 24);
        ang = $urandom_range(0, 359);
        rad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
        with_first = $urandom_range(0, 9) != 0;
        with_last  = $urandom_range(0, 9) != 0;
        drain      = $urandom_range(0, 19) == 0;
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 7) == 0) ang = $urandom_range(0, 359);
          queue_step(ang, rad, with_first && j == 0, with_last && j == len - 1,
                     drain && j == 0);
          rad = rad + $urandom_range(0, 2);
          if (rad > 255) rad = 255;
        end
        rand_items += len;
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (step_queue.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (pending_points.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(LimitCycles * 20);
    $display("TEST FAILED");
    $finish;
  end

endmodule
